@@ hdl/lcba_pkg.sv @@
`default_nettype none
package lcba_pkg;

  localparam int unsigned THICK_W = 30;
  localparam int unsigned SLICE_W = 20;
  localparam int unsigned DENS_W  = 24;
  localparam int unsigned AREA_W  = 55;
  localparam int unsigned LIMIT_W = 47;
  localparam int unsigned PROD_W  = 45;
  localparam int unsigned GROWN_W = 31;
  localparam int unsigned DIVN_W  = AREA_W + 1;

  localparam logic [DENS_W-1:0] DENS_MAX = {1'b0, {(DENS_W-1){1'b1}}};
  localparam logic [DENS_W-1:0] DENS_MIN = {1'b1, {(DENS_W-1){1'b0}}};
  localparam logic [AREA_W-1:0] AREA_MAX = {1'b0, {(AREA_W-1){1'b1}}};
  localparam logic [AREA_W-1:0] AREA_MIN = {1'b1, {(AREA_W-1){1'b0}}};
  localparam logic [THICK_W-1:0] THICK_MAX = {THICK_W{1'b1}};

  localparam logic [3:0] ADDR_AREA_LIMIT = 4'd0;

  typedef enum logic [1:0] {PH_SUB, PH_OPEN, PH_LAYER} phase_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PREP, ST_DISPATCH, ST_DECIDE, ST_DIV, ST_FINAL, ST_SEND
  } state_t;

  typedef enum logic [1:0] {OSEL_PASS, OSEL_ZERO, OSEL_MEAN, OSEL_FINAL} osel_t;

  typedef struct packed {
    logic  load;
    logic  stage1;
    logic  mul;
    logic  add;
    logic  open;
    logic  clear;
    logic  div_start;
    logic  out_load;
    osel_t out_sel;
  } cmd_t;

  typedef struct packed {
    logic brk;
    logic thick_zero;
    logic last;
    logic div_done;
  } status_t;

endpackage
`default_nettype wire

@@ hdl/layer_contract_by_area_top.sv @@
// Contracts a depth profile, one slice per input beat, into layers. The
// first slice is echoed as the substrate; later slices merge into a layer
// until the previous slice had a nonzero interface or spread times grown
// thickness passes area_limit. A closed layer reports summed thickness,
// rounded thickness-weighted mean densities and its last interface; the
// surface layer reports the last slice's densities and zero interface. An
// item passes the load, min/max-and-product, spread multiply and compare
// steps when it only merges; a substrate or a slice that opens a layer
// skips the spread multiply and compare. Closing a layer adds the
// bit-serial 56-step mean divider and any output stall; a layer of zero
// thickness reports its last slice's densities. One item is in flight.
`default_nettype none
module layer_contract_by_area_top import lcba_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [3:0]               paddr,
  input  wire logic [63:0]              pwdata,
  output logic [63:0]                   prdata,
  output logic                          pready,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [SLICE_W-1:0]       slice_thickness,
  input  wire logic [SLICE_W-1:0]       interface_width,
  input  wire logic signed [DENS_W-1:0] slice_rho,
  input  wire logic signed [DENS_W-1:0] slice_irho,
  input  wire logic                     last_slice,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [THICK_W-1:0]            layer_thickness,
  output logic [SLICE_W-1:0]            layer_interface,
  output logic signed [DENS_W-1:0]      layer_rho,
  output logic signed [DENS_W-1:0]      layer_irho,
  output logic                          last_layer
);
  logic [LIMIT_W-1:0] area_limit;
  cmd_t               cmd;
  status_t            sts;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_AREA_LIMIT) ? 64'(area_limit) : '0;

  always_ff @(posedge clk) begin
    if (rst) area_limit <= '0;
    else if (psel && penable && pwrite && paddr == ADDR_AREA_LIMIT)
      area_limit <= pwdata[LIMIT_W-1:0];
  end

  lcba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lcba_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .area_limit      (area_limit),
    .slice_thickness (slice_thickness),
    .interface_width (interface_width),
    .slice_rho       (slice_rho),
    .slice_irho      (slice_irho),
    .last_slice      (last_slice),
    .layer_thickness (layer_thickness),
    .layer_interface (layer_interface),
    .layer_rho       (layer_rho),
    .layer_irho      (layer_irho),
    .last_layer      (last_layer)
  );

endmodule
`default_nettype wire

@@ hdl/lcba_div.sv @@
`default_nettype none
module lcba_div import lcba_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic                      neg,
  input  wire logic [DIVN_W-1:0]         num,
  input  wire logic [THICK_W-1:0]        den,
  output logic                           done,
  output logic signed [DENS_W-1:0]       quot
);
  localparam int unsigned CW = $clog2(DIVN_W);
  localparam logic [CW-1:0] LAST_STEP = CW'(DIVN_W - 1);

  logic [DIVN_W-1:0]  q;
  logic [THICK_W-1:0] rem;
  logic [THICK_W-1:0] dv;
  logic [CW-1:0]      cnt;
  logic               busy;
  logic               sgn;
  logic [THICK_W:0]   trial;
  logic               fits;

  assign trial = {rem, q[DIVN_W-1]};
  assign fits  = trial >= {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= num;
      rem <= '0;
      dv  <= den;
      sgn <= neg;
    end else if (busy) begin
      q   <= {q[DIVN_W-2:0], fits};
      rem <= fits ? THICK_W'(trial - {1'b0, dv}) : trial[THICK_W-1:0];
    end
  end

  // round-half-away already folded into num; saturate to the density range
  always_comb begin
    if (sgn) begin
      if (q[DIVN_W-1:DENS_W] != '0 || (q[DENS_W-1] && q[DENS_W-2:0] != '0))
        quot = DENS_MIN;
      else
        quot = DENS_W'(~q[DENS_W-1:0] + 1'b1);
    end else begin
      if (q[DIVN_W-1:DENS_W-1] != '0) quot = DENS_MAX;
      else quot = q[DENS_W-1:0];
    end
  end

`ifndef SYNTH
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while busy");
`endif

endmodule
`default_nettype wire

@@ hdl/lcba_dp.sv @@
`default_nettype none
module lcba_dp import lcba_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire cmd_t                     cmd,
  output status_t                       sts,
  input  wire logic [LIMIT_W-1:0]       area_limit,
  input  wire logic [SLICE_W-1:0]       slice_thickness,
  input  wire logic [SLICE_W-1:0]       interface_width,
  input  wire logic signed [DENS_W-1:0] slice_rho,
  input  wire logic signed [DENS_W-1:0] slice_irho,
  input  wire logic                     last_slice,
  output logic [THICK_W-1:0]            layer_thickness,
  output logic [SLICE_W-1:0]            layer_interface,
  output logic signed [DENS_W-1:0]      layer_rho,
  output logic signed [DENS_W-1:0]      layer_irho,
  output logic                          last_layer
);
  // beat captured from the input channel
  logic [SLICE_W-1:0]       in_d, in_if;
  logic signed [DENS_W-1:0] in_r, in_ir;
  logic                     in_last;

  // open layer
  logic [THICK_W-1:0]       thick_sum;
  logic signed [AREA_W-1:0] rarea, iarea;
  logic signed [DENS_W-1:0] rlo, rhi, ilo, ihi, prev_r, prev_ir;
  logic [SLICE_W-1:0]       prev_if;

  // first stage
  logic signed [DENS_W-1:0] rlo_c, rhi_c, ilo_c, ihi_c;
  logic [GROWN_W-1:0]       grown;
  logic signed [PROD_W-1:0] rprod, iprod;

  // second stage
  logic [AREA_W-1:0]        rsp_prod, isp_prod;
  logic signed [DENS_W:0]   rdiff, idiff;

  logic [GROWN_W-1:0]       t_next;
  logic signed [AREA_W:0]   rs_next, is_next;
  logic [THICK_W-1:0]       thick_add;
  logic signed [AREA_W-1:0] rarea_add, iarea_add;

  logic [AREA_W-1:0]        rmag, imag;
  logic signed [DENS_W-1:0] rq, iq;
  logic                     rdone, idone;

  assign rdiff = {rhi_c[DENS_W-1], rhi_c} - {rlo_c[DENS_W-1], rlo_c};
  assign idiff = {ihi_c[DENS_W-1], ihi_c} - {ilo_c[DENS_W-1], ilo_c};

  assign t_next    = {1'b0, thick_sum} + GROWN_W'(in_d);
  assign thick_add = t_next[THICK_W] ? THICK_MAX : t_next[THICK_W-1:0];
  assign rs_next   = (AREA_W+1)'(rarea) + (AREA_W+1)'(rprod);
  assign is_next   = (AREA_W+1)'(iarea) + (AREA_W+1)'(iprod);
  assign rarea_add = (rs_next[AREA_W] != rs_next[AREA_W-1])
                     ? (rs_next[AREA_W] ? AREA_MIN : AREA_MAX) : rs_next[AREA_W-1:0];
  assign iarea_add = (is_next[AREA_W] != is_next[AREA_W-1])
                     ? (is_next[AREA_W] ? AREA_MIN : AREA_MAX) : is_next[AREA_W-1:0];

  assign rmag = rarea[AREA_W-1] ? AREA_W'(-rarea) : AREA_W'(rarea);
  assign imag = iarea[AREA_W-1] ? AREA_W'(-iarea) : AREA_W'(iarea);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_d    <= slice_thickness;
      in_if   <= interface_width;
      in_r    <= slice_rho;
      in_ir   <= slice_irho;
      in_last <= last_slice;
    end
    if (cmd.stage1) begin
      rlo_c <= (in_r < rlo) ? in_r : rlo;
      rhi_c <= (in_r > rhi) ? in_r : rhi;
      ilo_c <= (in_ir < ilo) ? in_ir : ilo;
      ihi_c <= (in_ir > ihi) ? in_ir : ihi;
      grown <= t_next;
      rprod <= $signed({1'b0, in_d}) * in_r;
      iprod <= $signed({1'b0, in_d}) * in_ir;
    end
    if (cmd.mul) begin
      rsp_prod <= rdiff[DENS_W-1:0] * grown;
      isp_prod <= idiff[DENS_W-1:0] * grown;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      thick_sum <= '0;
      rarea     <= '0;
      iarea     <= '0;
      rlo       <= '0;
      rhi       <= '0;
      ilo       <= '0;
      ihi       <= '0;
      prev_if   <= '0;
      prev_r    <= '0;
      prev_ir   <= '0;
    end else if (cmd.open) begin
      thick_sum <= THICK_W'(in_d);
      rarea     <= AREA_W'(rprod);
      iarea     <= AREA_W'(iprod);
      rlo       <= in_r;
      rhi       <= in_r;
      ilo       <= in_ir;
      ihi       <= in_ir;
      prev_if   <= in_if;
      prev_r    <= in_r;
      prev_ir   <= in_ir;
    end else if (cmd.add) begin
      thick_sum <= thick_add;
      rarea     <= rarea_add;
      iarea     <= iarea_add;
      rlo       <= rlo_c;
      rhi       <= rhi_c;
      ilo       <= ilo_c;
      ihi       <= ihi_c;
      prev_if   <= in_if;
      prev_r    <= in_r;
      prev_ir   <= in_ir;
    end
  end

  lcba_div u_div_rho (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .neg   (rarea[AREA_W-1]),
    .num   ({1'b0, rmag} + DIVN_W'(thick_sum[THICK_W-1:1])),
    .den   (thick_sum),
    .done  (rdone),
    .quot  (rq)
  );

  lcba_div u_div_irho (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .neg   (iarea[AREA_W-1]),
    .num   ({1'b0, imag} + DIVN_W'(thick_sum[THICK_W-1:1])),
    .den   (thick_sum),
    .done  (idone),
    .quot  (iq)
  );

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      case (cmd.out_sel)
        OSEL_PASS: begin
          layer_thickness <= THICK_W'(in_d);
          layer_interface <= in_last ? '0 : in_if;
          layer_rho       <= in_r;
          layer_irho      <= in_ir;
          last_layer      <= in_last;
        end
        OSEL_ZERO: begin
          layer_thickness <= '0;
          layer_interface <= prev_if;
          layer_rho       <= prev_r;
          layer_irho      <= prev_ir;
          last_layer      <= 1'b0;
        end
        OSEL_MEAN: begin
          layer_thickness <= thick_sum;
          layer_interface <= prev_if;
          layer_rho       <= rq;
          layer_irho      <= iq;
          last_layer      <= 1'b0;
        end
        default: begin
          layer_thickness <= thick_sum;
          layer_interface <= '0;
          layer_rho       <= in_r;
          layer_irho      <= in_ir;
          last_layer      <= 1'b1;
        end
      endcase
    end
  end

  assign sts.brk = (prev_if != '0) || (rsp_prod > AREA_W'(area_limit))
                   || (isp_prod > AREA_W'(area_limit));
  assign sts.thick_zero = (thick_sum == '0);
  assign sts.last       = in_last;
  assign sts.div_done   = rdone && idone;

`ifndef SYNTH
  a_zero_area: assert property (@(posedge clk) disable iff (rst)
    (thick_sum == '0) |-> (rarea == '0 && iarea == '0))
    else $error("area sum without thickness");
`endif

endmodule
`default_nettype wire

@@ hdl/lcba_ctrl.sv @@
`default_nettype none
module lcba_ctrl import lcba_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  wire logic    out_ready,
  input  wire status_t sts,
  output cmd_t         cmd
);
  state_t state, state_next;
  phase_t phase, phase_next;
  logic   go_final, go_final_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      phase    <= PH_SUB;
      go_final <= 1'b0;
    end else begin
      state    <= state_next;
      phase    <= phase_next;
      go_final <= go_final_next;
    end
  end

  always_comb begin
    state_next    = state;
    phase_next    = phase;
    go_final_next = go_final;
    cmd           = '0;
    cmd.out_sel   = OSEL_PASS;
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.stage1 = 1'b1;
        state_next = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        case (phase)
          PH_SUB: begin
            cmd.out_load  = 1'b1;
            cmd.out_sel   = OSEL_PASS;
            cmd.clear     = 1'b1;
            phase_next    = sts.last ? PH_SUB : PH_OPEN;
            go_final_next = 1'b0;
            state_next    = ST_SEND;
          end
          PH_OPEN: begin
            cmd.open   = 1'b1;
            phase_next = PH_LAYER;
            state_next = sts.last ? ST_FINAL : ST_IDLE;
          end
          default: begin
            cmd.mul    = 1'b1;
            state_next = ST_DECIDE;
          end
        endcase
      end
      ST_DECIDE: begin
        if (!sts.brk) begin
          cmd.add    = 1'b1;
          state_next = sts.last ? ST_FINAL : ST_IDLE;
        end else if (sts.thick_zero) begin
          cmd.out_load  = 1'b1;
          cmd.out_sel   = OSEL_ZERO;
          cmd.open      = 1'b1;
          go_final_next = sts.last;
          state_next    = ST_SEND;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts.div_done) begin
          cmd.out_load  = 1'b1;
          cmd.out_sel   = OSEL_MEAN;
          cmd.open      = 1'b1;
          go_final_next = sts.last;
          state_next    = ST_SEND;
        end
      end
      ST_FINAL: begin
        cmd.out_load  = 1'b1;
        cmd.out_sel   = OSEL_FINAL;
        cmd.clear     = 1'b1;
        phase_next    = PH_SUB;
        go_final_next = 1'b0;
        state_next    = ST_SEND;
      end
      ST_SEND: begin
        out_valid = 1'b1;
        if (out_ready) state_next = go_final ? ST_FINAL : ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

`ifndef SYNTH
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input and output open together");
  a_div_layer: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (phase == PH_LAYER))
    else $error("division outside a layer");
  a_final_last: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINAL) |-> sts.last)
    else $error("final layer without last slice");
`endif

endmodule
`default_nettype wire
